// ===== design/uue_pkg.sv =====
// Shared types and constants for the uuencode line encoder.
// No dependencies; imported by every module of the block but the RAM and the checker.
`default_nettype none

package uue_pkg;

  // Line length field; wide enough for the largest supported line (63 bytes).
  localparam int unsigned LEN_W = 6;

  localparam logic [4:0] SEQ_RESET  = 5'd25;   // letter 'z'
  localparam logic [4:0] SEQ_LAST   = 5'd0;    // letter 'a'
  localparam logic [6:0] CHAR_LOW_A = 7'h61;   // ASCII 'a'
  localparam logic [2:0] CNT_ONE    = 3'd1;
  localparam logic [2:0] CNT_FOUR   = 3'd4;

  // Line command handed from the front to the back.
  typedef struct packed {
    logic             bank;   // line buffer holding the bytes
    logic [LEN_W-1:0] len;    // bytes in the line
    logic             fin;    // finish transaction: terminator line follows
  } uue_cmd_t;

  // Back returns a line buffer to the front once it is fully read.
  typedef struct packed {
    logic valid;
    logic bank;
  } uue_release_t;

  // Six bits to a printable character.
  function automatic logic [6:0] enc6(input logic [5:0] v);
    enc6 = {1'b0, v} + 7'd32;
  endfunction

endpackage

`default_nettype wire

// ===== design/uue_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module uue_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 90,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/uue_cmd_fifo.sv =====
// Two-entry queue of line commands between front and back.
// Depends on uue_pkg.
`default_nettype none

module uue_cmd_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire uue_pkg::uue_cmd_t push_cmd_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output uue_pkg::uue_cmd_t      pop_cmd_o,
  output logic                   empty_o
);
  import uue_pkg::*;

  uue_cmd_t   entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o    = (count_q == 2'd2);
  assign empty_o   = (count_q == 2'd0);
  assign pop_cmd_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/uue_front.sv =====
// Input side: stores bytes into two line buffers and queues line commands.
// Depends on uue_pkg.
`default_nettype none

module uue_front #(
  parameter int unsigned LINE_BYTES = 45,
  parameter int unsigned AW         = $clog2(2 * LINE_BYTES)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 in_fin_i,
  input  wire logic [7:0]           in_byte_i,
  output logic                      wr_en_o,
  output logic      [AW-1:0]        wr_addr_o,
  output logic      [7:0]           wr_data_o,
  output logic                      push_o,
  output uue_pkg::uue_cmd_t         push_cmd_o,
  input  wire logic                 fifo_full_i,
  input  wire uue_pkg::uue_release_t release_i
);
  import uue_pkg::*;

  localparam logic [LEN_W-1:0] LineLen = LEN_W'(LINE_BYTES);

  logic [LEN_W-1:0] fill_q, fill_d;
  logic             bank_q, bank_d;
  logic [1:0]       busy_q, busy_d;
  logic             accept;
  logic             line_full;
  logic [AW:0]      addr_sum;

  assign in_ready_o = !busy_q[bank_q] && !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign line_full  = (fill_q == LineLen - LEN_W'(1));

  assign addr_sum  = (bank_q ? (AW+1)'(LINE_BYTES) : '0) + (AW+1)'(fill_q);
  assign wr_en_o   = accept && !in_fin_i;
  assign wr_addr_o = addr_sum[AW-1:0];
  assign wr_data_o = in_byte_i;

  assign push_o          = accept && (in_fin_i || line_full);
  assign push_cmd_o.bank = bank_q;
  assign push_cmd_o.len  = in_fin_i ? fill_q : LineLen;
  assign push_cmd_o.fin  = in_fin_i;

  always_comb begin
    fill_d = fill_q;
    bank_d = bank_q;
    busy_d = busy_q;
    if (release_i.valid) begin
      busy_d[release_i.bank] = 1'b0;
    end
    if (push_o) begin
      // hand the buffer to the back and switch to the other one
      busy_d[bank_q] = 1'b1;
      bank_d         = ~bank_q;
      fill_d         = '0;
    end else if (wr_en_o) begin
      fill_d = fill_q + LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      bank_q <= 1'b0;
      busy_q <= 2'b00;
    end else begin
      fill_q <= fill_d;
      bank_q <= bank_d;
      busy_q <= busy_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/uue_back.sv =====
// Output side: sequencer that reads a line buffer and emits encoded results.
// Depends on uue_pkg.
`default_nettype none

module uue_back #(
  parameter int unsigned LINE_BYTES = 45,
  parameter int unsigned AW         = $clog2(2 * LINE_BYTES)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              append_seq_i,
  input  wire logic              fifo_empty_i,
  input  wire uue_pkg::uue_cmd_t cmd_i,
  output logic                   pop_o,
  output logic                   rd_en_o,
  output logic      [AW-1:0]     rd_addr_o,
  input  wire logic [7:0]        rd_data_i,
  output uue_pkg::uue_release_t  release_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [6:0]        char_a_o,
  output logic      [6:0]        char_b_o,
  output logic      [6:0]        char_c_o,
  output logic      [6:0]        char_d_o,
  output logic      [2:0]        char_count_o,
  output logic                   line_end_o,
  output logic                   last_o
);
  import uue_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LEN  = 5'b00010,
    S_RD   = 5'b00100,
    S_GRP  = 5'b01000,
    S_SEQ  = 5'b10000
  } back_state_e;

  back_state_e      st_q, st_d;
  logic             bank_q, bank_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             fin_q, fin_d;
  logic             term_q, term_d;
  logic [LEN_W-1:0] idx_q, idx_d;
  logic [1:0]       sel_q, sel_d;
  logic [7:0]       b0_q, b0_d, b1_q, b1_d;
  logic [4:0]       letter_q, letter_d;

  logic             out_valid_q, out_valid_d;
  logic [6:0]       ca_q, ca_d, cb_q, cb_d, cc_q, cc_d, cd_q, cd_d;
  logic [2:0]       cnt_q, cnt_d;
  logic             lend_q, lend_d, last_q, last_d;

  logic             out_free;
  logic             emit;
  logic             line_done;
  logic             last_line;
  logic [LEN_W:0]   idx_ext, len_ext;
  logic [AW:0]      addr_sum;
  logic [7:0]       g1, g2;
  logic             grp_end;

  assign out_free  = !out_valid_q || out_ready_i;
  assign last_line = !fin_q || term_q;
  assign idx_ext   = {1'b0, idx_q};
  assign len_ext   = {1'b0, len_q};
  assign grp_end   = (idx_ext + (LEN_W+1)'(3)) >= len_ext;

  // bytes past the end of a partial group read as zero
  assign g1 = ((idx_ext + (LEN_W+1)'(1)) < len_ext) ? b1_q : 8'h00;
  assign g2 = ((idx_ext + (LEN_W+1)'(2)) < len_ext) ? rd_data_i : 8'h00;

  assign addr_sum  = (bank_q ? (AW+1)'(LINE_BYTES) : '0) + (AW+1)'(idx_q) + (AW+1)'(sel_q);
  assign rd_addr_o = addr_sum[AW-1:0];
  assign rd_en_o   = (st_q == S_RD) && ((idx_ext + (LEN_W+1)'(sel_q)) < len_ext);

  always_comb begin
    st_d      = st_q;
    bank_d    = bank_q;
    len_d     = len_q;
    fin_d     = fin_q;
    term_d    = term_q;
    idx_d     = idx_q;
    sel_d     = sel_q;
    b0_d      = b0_q;
    b1_d      = b1_q;
    letter_d  = letter_q;
    ca_d      = ca_q;
    cb_d      = cb_q;
    cc_d      = cc_q;
    cd_d      = cd_q;
    cnt_d     = cnt_q;
    lend_d    = lend_q;
    last_d    = last_q;
    pop_o     = 1'b0;
    emit      = 1'b0;
    line_done = 1'b0;
    release_o = '0;

    case (st_q)
      S_IDLE: begin
        if (!fifo_empty_i) begin
          pop_o  = 1'b1;
          bank_d = cmd_i.bank;
          len_d  = cmd_i.len;
          fin_d  = cmd_i.fin;
          term_d = cmd_i.fin && (cmd_i.len == '0);
          st_d   = S_LEN;
        end
      end
      S_LEN: begin
        if (out_free) begin
          emit   = 1'b1;
          ca_d   = enc6(len_q);
          cb_d   = '0;
          cc_d   = '0;
          cd_d   = '0;
          cnt_d  = CNT_ONE;
          lend_d = (len_q == '0) && !append_seq_i;
          last_d = (len_q == '0) && !append_seq_i && last_line;
          idx_d  = '0;
          sel_d  = '0;
          if (len_q != '0) begin
            st_d = S_RD;
          end else if (append_seq_i) begin
            st_d = S_SEQ;
          end else begin
            line_done = 1'b1;
          end
        end
      end
      S_RD: begin
        // read data is registered and arrives in the cycle after its address
        if (sel_q == 2'd1) begin
          b0_d = rd_data_i;
        end
        if (sel_q == 2'd2) begin
          b1_d = rd_data_i;
          st_d = S_GRP;
        end
        sel_d = sel_q + 2'd1;
      end
      S_GRP: begin
        if (out_free) begin
          emit   = 1'b1;
          ca_d   = enc6(b0_q[7:2]);
          cb_d   = enc6({b0_q[1:0], g1[7:4]});
          cc_d   = enc6({g1[3:0], g2[7:6]});
          cd_d   = enc6(g2[5:0]);
          cnt_d  = CNT_FOUR;
          lend_d = grp_end && !append_seq_i;
          last_d = grp_end && !append_seq_i && last_line;
          idx_d  = idx_q + LEN_W'(3);
          sel_d  = '0;
          if (!grp_end) begin
            st_d = S_RD;
          end else if (append_seq_i) begin
            st_d = S_SEQ;
          end else begin
            line_done = 1'b1;
          end
        end
      end
      S_SEQ: begin
        if (out_free) begin
          emit      = 1'b1;
          ca_d      = CHAR_LOW_A + {2'b00, letter_q};
          cb_d      = '0;
          cc_d      = '0;
          cd_d      = '0;
          cnt_d     = CNT_ONE;
          lend_d    = 1'b1;
          last_d    = last_line;
          letter_d  = (letter_q == SEQ_LAST) ? SEQ_RESET : letter_q - 5'd1;
          line_done = 1'b1;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase

    if (line_done) begin
      if (fin_q && !term_q) begin
        // partial line of a finish done; terminator line comes next
        term_d = 1'b1;
        len_d  = '0;
        st_d   = S_LEN;
      end else begin
        release_o.valid = 1'b1;
        release_o.bank  = bank_q;
        if (fin_q) begin
          letter_d = SEQ_RESET;
        end
        st_d = S_IDLE;
      end
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      fin_q       <= 1'b0;
      term_q      <= 1'b0;
      letter_q    <= SEQ_RESET;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      fin_q       <= fin_d;
      term_q      <= term_d;
      letter_q    <= letter_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bank_q <= bank_d;
    len_q  <= len_d;
    idx_q  <= idx_d;
    sel_q  <= sel_d;
    b0_q   <= b0_d;
    b1_q   <= b1_d;
    ca_q   <= ca_d;
    cb_q   <= cb_d;
    cc_q   <= cc_d;
    cd_q   <= cd_d;
    cnt_q  <= cnt_d;
    lend_q <= lend_d;
    last_q <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign char_a_o     = ca_q;
  assign char_b_o     = cb_q;
  assign char_c_o     = cc_q;
  assign char_d_o     = cd_q;
  assign char_count_o = cnt_q;
  assign line_end_o   = lend_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

// ===== design/uuencode_line_encoder.sv =====
// Throughput: one input byte per cycle while a line buffer is free (two buffers)
// and the command queue has room. A byte that fills a line queues a line command;
// the back pops it when idle, then registers the length result. Each 3-byte group
// is read over the buffer's single read port, then emitted once the output is free.
// Reset: asynchronous, active low; clears control, sequence letter to 'z',
// append_sequence to 1. Line buffer contents are not cleared.
`default_nettype none

module uuencode_line_encoder #(
  parameter int unsigned LINE_BYTES = 45
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic [0:0]  s_axis_tuser_i,   // [0] action (1 = finish)
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [31:0] m_axis_tdata_o,   // [6:0] char_a, [13:7] char_b,
                                             // [20:14] char_c, [27:21] char_d,
                                             // [30:28] char_count, [31] zero
  output logic      [0:0]  m_axis_tuser_o,   // [0] line_end
  output logic             m_axis_tlast_o,   // last result of the input transaction
  // configuration
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [2:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output logic      [31:0] prdata_o,
  output logic             pready_o
);
  import uue_pkg::*;

  localparam int unsigned Depth = 2 * LINE_BYTES;
  localparam int unsigned AW    = $clog2(Depth);
  localparam logic        RegAppendSeq = 1'b0;

  logic         append_q, append_d;
  logic         cfg_wr;

  logic         wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]   wr_data, rd_data;
  logic         push, pop, fifo_full, fifo_empty;
  uue_cmd_t     push_cmd, pop_cmd;
  uue_release_t release_s;

  logic [6:0]   char_a, char_b, char_c, char_d;
  logic [2:0]   char_count;
  logic         line_end;

  // configuration register
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o;
  assign append_d = (cfg_wr && (paddr_i[2] == RegAppendSeq)) ? pwdata_i[0] : append_q;
  assign prdata_o = (paddr_i[2] == RegAppendSeq) ? {31'd0, append_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      append_q <= 1'b1;
    end else begin
      append_q <= append_d;
    end
  end

  uue_front #(
    .LINE_BYTES (LINE_BYTES),
    .AW         (AW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_fin_i    (s_axis_tuser_i[0]),
    .in_byte_i   (s_axis_tdata_i),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .push_o      (push),
    .push_cmd_o  (push_cmd),
    .fifo_full_i (fifo_full),
    .release_i   (release_s)
  );

  uue_ram #(
    .WIDTH (8),
    .DEPTH (Depth),
    .AW    (AW)
  ) u_line_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  uue_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (fifo_full),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .empty_o    (fifo_empty)
  );

  uue_back #(
    .LINE_BYTES (LINE_BYTES),
    .AW         (AW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .append_seq_i (append_q),
    .fifo_empty_i (fifo_empty),
    .cmd_i        (pop_cmd),
    .pop_o        (pop),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .release_o    (release_s),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .char_a_o     (char_a),
    .char_b_o     (char_b),
    .char_c_o     (char_c),
    .char_d_o     (char_d),
    .char_count_o (char_count),
    .line_end_o   (line_end),
    .last_o       (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, char_count, char_d, char_c, char_b, char_a};
  assign m_axis_tuser_o = line_end;

endmodule

`default_nettype wire

// ===== design/uue_checker.sv =====
// Port-level checks for the uuencode line encoder, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none

module uue_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o,
  input wire logic [0:0]  m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);

  // results carry either one or four characters
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[30:28] == 3'd1 || m_axis_tdata_o[30:28] == 3'd4))
    else $error("char_count not 1 or 4");

  // single-character results leave the other characters zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[30:28] == 3'd1) |-> (m_axis_tdata_o[27:7] == 21'd0))
    else $error("unused characters not zero");

  // the final result of a transaction always closes a line
  a_last_lend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> m_axis_tuser_o[0])
    else $error("tlast without line_end");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

endmodule

bind uuencode_line_encoder uue_checker u_uue_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for uuencode_line_encoder: stream stimulus, APB register
// writes, and a line encoder predictor that checks every result transaction.
// Depends on design/uue_pkg.sv and design/uuencode_line_encoder.sv.
module testbench;
  import uue_pkg::*;

  localparam int LINE_LEN = 45;
  localparam int STALL_LIMIT = 2000;
  localparam int unsigned REG_APPEND_SEQ = 0;
  localparam logic [6:0] NO_HAND = 7'h00;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_Z = 7'h7a;

  typedef enum logic {ACT_DATA = 1'b0, ACT_FINISH = 1'b1} act_e;

  typedef struct packed {
    logic [6:0] ch_a;
    logic [6:0] ch_b;
    logic [6:0] ch_c;
    logic [6:0] ch_d;
    logic [2:0] count;
    logic       line_end;
    logic       last;
  } enc_res_t;

  typedef struct {
    act_e       act;
    logic [7:0] data;
    logic [6:0] hand_len;  // typed-in length char, NO_HAND means predictor only
    logic [6:0] hand_seq;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = 8'h00;
  logic [0:0]  s_tuser = 1'b0;
  logic        m_tready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;

  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic [31:0] prdata_o;
  logic        pready_o;

  // predictor state
  logic [7:0] line_bytes_q[$];
  logic [4:0] seq_letter = SEQ_RESET;
  logic       seq_on = 1'b1;
  enc_res_t   item_res[$];
  enc_res_t   line_out_q[$];
  enc_res_t   want;

  int  n_err = 0;
  int  stall_cycles = 0;
  bit  calm = 1'b0;

  uuencode_line_encoder #(.LINE_BYTES(LINE_LEN)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata_o),
    .pready_o        (pready_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [6:0] to_char(input logic [5:0] v);
    return 7'd32 + {1'b0, v};
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got);
    if (got !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got);
      n_err++;
    end
  endfunction

  // Encodes the first n pending bytes as one line, appending to item_res.
  function automatic void encode_line(input int n);
    enc_res_t   r;
    logic [7:0] b0, b1, b2;
    r = '0;
    r.ch_a = to_char(6'(n));
    r.count = CNT_ONE;
    r.line_end = (n == 0) && !seq_on;
    item_res.push_back(r);
    for (int i = 0; i < n; i += 3) begin
      b0 = line_bytes_q[i];
      b1 = (i + 1 < n) ? line_bytes_q[i + 1] : 8'h00;
      b2 = (i + 2 < n) ? line_bytes_q[i + 2] : 8'h00;
      r.ch_a = to_char(b0[7:2]);
      r.ch_b = to_char({b0[1:0], b1[7:4]});
      r.ch_c = to_char({b1[3:0], b2[7:6]});
      r.ch_d = to_char(b2[5:0]);
      r.count = CNT_FOUR;
      r.line_end = (i + 3 >= n) && !seq_on;
      item_res.push_back(r);
    end
    if (seq_on) begin
      r = '0;
      r.ch_a = CHAR_LOW_A + {2'b00, seq_letter};
      r.count = CNT_ONE;
      r.line_end = 1'b1;
      item_res.push_back(r);
      seq_letter = (seq_letter == SEQ_LAST) ? SEQ_RESET : seq_letter - 5'd1;
    end
  endfunction

  function automatic void predict_item(input act_e act, input logic [7:0] b);
    item_res.delete();
    if (act == ACT_DATA) begin
      line_bytes_q.push_back(b);
      if (line_bytes_q.size() == LINE_LEN) begin
        encode_line(LINE_LEN);
        line_bytes_q.delete();
      end
    end else begin
      if (line_bytes_q.size() > 0) encode_line(line_bytes_q.size());
      encode_line(0);  // terminator line
      line_bytes_q.delete();
      seq_letter = SEQ_RESET;
    end
    if (item_res.size() > 0) item_res[item_res.size() - 1].last = 1'b1;
  endfunction

  function automatic logic [7:0] rand_byte();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return 8'h00;
    if (pick < 16) return 8'hff;
    return 8'($urandom);
  endfunction

  // tvalid is only lowered on an idle cycle, so it never toggles within one step
  task automatic send_item(input act_e act, input logic [7:0] b,
                           input logic [6:0] hand_len, input logic [6:0] hand_seq);
    enc_res_t r;
    while (!calm && $urandom_range(99) < 6) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= act;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_item(act, b);
    if (hand_len != NO_HAND) begin
      item_res.delete();
      r = '0;
      r.ch_a = hand_len;
      r.count = CNT_ONE;
      item_res.push_back(r);
      r.ch_a = hand_seq;
      r.line_end = 1'b1;
      r.last = 1'b1;
      item_res.push_back(r);
    end
    foreach (item_res[k]) line_out_q.push_back(item_res[k]);
  endtask

  // Drains the block; extra cycles cover the back end finishing its last line.
  task automatic end_phase();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (line_out_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic set_append(input logic v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * REG_APPEND_SEQ);
    pwdata <= {31'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    seq_on = v;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    check_field("prdata", {31'd0, v}, prdata_o);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_bursts(input int n_items);
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 10) len = 0;
      else if (pick < 65) len = $urandom_range(8, 1);
      else if (pick < 90) len = $urandom_range(44, 9);
      else len = $urandom_range(100, 45);
      for (int j = 0; j < len; j++) send_item(ACT_DATA, rand_byte(), NO_HAND, NO_HAND);
      // some bursts run on into the next one without a finish
      if ($urandom_range(99) < 85) send_item(ACT_FINISH, 8'($urandom), NO_HAND, NO_HAND);
      sent += len + 1;
    end
    send_item(ACT_FINISH, 8'($urandom), NO_HAND, NO_HAND);
  endtask

  stim_row_t dir_rows[17] = '{
    '{ACT_FINISH, 8'h00, CH_SPACE, CH_Z},  // empty finish right after reset
    '{ACT_DATA,   8'h00, NO_HAND,  NO_HAND},
    '{ACT_FINISH, 8'hff, NO_HAND,  NO_HAND},  // one-byte partial group
    '{ACT_DATA,   8'hff, NO_HAND,  NO_HAND},
    '{ACT_DATA,   8'h01, NO_HAND,  NO_HAND},
    '{ACT_FINISH, 8'h00, NO_HAND,  NO_HAND},  // two-byte partial group
    '{ACT_DATA,   8'hff, NO_HAND,  NO_HAND},
    '{ACT_DATA,   8'h00, NO_HAND,  NO_HAND},
    '{ACT_DATA,   8'haa, NO_HAND,  NO_HAND},
    '{ACT_FINISH, 8'h55, NO_HAND,  NO_HAND},
    '{ACT_DATA,   8'h55, NO_HAND,  NO_HAND},
    '{ACT_DATA,   8'h80, NO_HAND,  NO_HAND},
    '{ACT_DATA,   8'h7f, NO_HAND,  NO_HAND},
    '{ACT_DATA,   8'h01, NO_HAND,  NO_HAND},
    '{ACT_FINISH, 8'h00, NO_HAND,  NO_HAND},
    '{ACT_FINISH, 8'hff, CH_SPACE, CH_Z},  // finish resets the letter to z
    '{ACT_FINISH, 8'h00, CH_SPACE, CH_Z}
  };

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_item(dir_rows[i].act, dir_rows[i].data, dir_rows[i].hand_len, dir_rows[i].hand_seq);
    end_phase();

    set_append(1'b0);
    random_bursts(90);
    end_phase();

    // three full lines back to back without a finish, no idling on either side
    set_append(1'b1);
    calm = 1'b1;
    for (int i = 0; i < 3 * LINE_LEN; i++) send_item(ACT_DATA, rand_byte(), NO_HAND, NO_HAND);
    send_item(ACT_FINISH, 8'h00, NO_HAND, NO_HAND);
    end_phase();
    calm = 1'b0;

    set_append(1'b0);
    random_bursts(90);
    end_phase();

    set_append(1'b1);
    random_bursts(90);
    end_phase();

    if (n_err == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 6);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (line_out_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata %0h", $time,
                 m_axis_tdata_o);
        n_err++;
      end else begin
        want = line_out_q.pop_front();
        check_field("char_a", 32'(want.ch_a), 32'(m_axis_tdata_o[6:0]));
        check_field("char_b", 32'(want.ch_b), 32'(m_axis_tdata_o[13:7]));
        check_field("char_c", 32'(want.ch_c), 32'(m_axis_tdata_o[20:14]));
        check_field("char_d", 32'(want.ch_d), 32'(m_axis_tdata_o[27:21]));
        check_field("char_count", 32'(want.count), 32'(m_axis_tdata_o[30:28]));
        check_field("tdata pad", 32'd0, 32'(m_axis_tdata_o[31]));
        check_field("line_end", 32'(want.line_end), 32'(m_axis_tuser_o[0]));
        check_field("last", 32'(want.last), 32'(m_axis_tlast_o));
      end
    end
  end

  // no transaction on either stream for too long means the block is stuck
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
